/* rtl/core/ppc_pkg.sv */
// ppc_pkg: shared constants, types and mask helper for the private
// polymorphism counter. No dependencies.
package ppc_pkg;

    localparam int NUM_POPS       = 8;
    localparam int MAX_HAPLOTYPES = 64;
    localparam int COUNT_WIDTH    = 16;
    localparam int OUT_WIDTH      = 16;
    localparam int SIZE_WIDTH     = 7;
    localparam int SUM_WIDTH      = 10;
    localparam int COL_WIDTH      = 64;
    localparam int POP_IDX_WIDTH  = 3;
    localparam int ADDR_WIDTH     = 5;
    localparam int APB_WIDTH      = 32;
    localparam int OUT_BITS       = NUM_POPS * OUT_WIDTH + 1;
    localparam int OUT_TDATA      = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [SIZE_WIDTH-1:0] SIZE_RESET = SIZE_WIDTH'(8);

    typedef logic [COL_WIDTH-1:0]   col_t;
    typedef logic [SIZE_WIDTH-1:0]  size_t;
    typedef logic [SUM_WIDTH-1:0]   sum_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [NUM_POPS-1:0]    poly_t;

    typedef struct packed {
        logic valid;
        logic last;
    } beat_ctrl_t;

    // Bits below k that also lie below the haplotype capacity.
    function automatic col_t low_mask(input sum_t k);
        col_t m;
        for (int i = 0; i < COL_WIDTH; i++)
        begin
            m[i] = (SUM_WIDTH'(i) < k) && (i < MAX_HAPLOTYPES);
        end
        return m;
    endfunction

endpackage

/* rtl/core/ppc_cfg.sv */
// ppc_cfg: APB register file for the eight population sizes and the
// registered segment masks and capacity check. Uses ppc_pkg.
module ppc_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ppc_pkg::ADDR_WIDTH-1:0]       paddr,
    input  logic [ppc_pkg::APB_WIDTH-1:0]        pwdata,
    output logic [ppc_pkg::APB_WIDTH-1:0]        prdata,
    output logic                                 pready,
    output ppc_pkg::col_t                        seg_mask [ppc_pkg::NUM_POPS],
    output logic                                 sizes_error
);

    ppc_pkg::size_t size_reg [ppc_pkg::NUM_POPS];
    ppc_pkg::col_t  mask_reg [ppc_pkg::NUM_POPS];
    ppc_pkg::col_t  mask_next [ppc_pkg::NUM_POPS];
    logic           err_reg;
    logic           err_next;
    ppc_pkg::sum_t  bound [ppc_pkg::NUM_POPS+1];

    logic [ppc_pkg::POP_IDX_WIDTH-1:0] idx;

    assign idx    = paddr[ppc_pkg::ADDR_WIDTH-1:2];
    assign pready = 1'b1;
    assign prdata = ppc_pkg::APB_WIDTH'(size_reg[idx]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < ppc_pkg::NUM_POPS; p++)
            begin
                size_reg[p] <= ppc_pkg::SIZE_RESET;
            end
        end
        else if (psel && penable && pwrite)
        begin
            size_reg[idx] <= pwdata[ppc_pkg::SIZE_WIDTH-1:0];
        end
    end

    // segment bounds as running sums of the sizes, then the segment masks and the capacity check
    always_comb
    begin
        bound[0] = '0;
        for (int p = 0; p < ppc_pkg::NUM_POPS; p++)
        begin
            bound[p+1] = bound[p] + ppc_pkg::SUM_WIDTH'(size_reg[p]);
        end
        for (int p = 0; p < ppc_pkg::NUM_POPS; p++)
        begin
            mask_next[p] = ppc_pkg::low_mask(bound[p+1]) & ~ppc_pkg::low_mask(bound[p]);
        end
        err_next = bound[ppc_pkg::NUM_POPS] > ppc_pkg::SUM_WIDTH'(ppc_pkg::MAX_HAPLOTYPES);
    end

    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        err_reg  <= err_next;
    end

    assign seg_mask    = mask_reg;
    assign sizes_error = err_reg;

endmodule

/* rtl/core/ppc_lane.sv */
// ppc_lane: polymorphism test of one population segment, registered.
// Uses ppc_pkg.
module ppc_lane
(
    input  logic          clk,
    input  logic          en,
    input  ppc_pkg::col_t column,
    input  ppc_pkg::col_t mask,
    output logic          poly
);

    ppc_pkg::col_t ones;
    logic          poly_reg;
    logic          poly_next;

    assign ones      = column & mask;
    assign poly_next = (ones != '0) && (ones != mask);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            poly_reg <= poly_next;
        end
    end

    assign poly = poly_reg;

endmodule

/* rtl/core/ppc_merge.sv */
// ppc_merge: combines lane results, keeps the saturating per-population
// counters and holds the output beat. Uses ppc_pkg.
module ppc_merge
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  ppc_pkg::beat_ctrl_t               ctrl,
    input  ppc_pkg::poly_t                    poly,
    input  logic                              sizes_error,
    output logic                              stall,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ppc_pkg::OUT_TDATA-1:0]     m_tdata
);

    ppc_pkg::count_t cnt_reg  [ppc_pkg::NUM_POPS];
    ppc_pkg::count_t cnt_next [ppc_pkg::NUM_POPS];
    logic            valid_reg;
    logic [ppc_pkg::OUT_TDATA-1:0] data_reg;
    logic [ppc_pkg::OUT_TDATA-1:0] data_next;
    logic            out_free;
    logic            fire;
    logic            private_site;

    assign out_free     = !valid_reg || m_tready;
    assign stall        = ctrl.valid && ctrl.last && !out_free;
    assign fire         = ctrl.valid && !stall;
    assign private_site = (poly != '0) && ((poly & (poly - 1'b1)) == '0);

    always_comb
    begin
        data_next = '0;
        for (int p = 0; p < ppc_pkg::NUM_POPS; p++)
        begin
            cnt_next[p] = cnt_reg[p];
            if (private_site && poly[p] && (cnt_reg[p] != '1))
            begin
                cnt_next[p] = cnt_reg[p] + 1'b1;
            end
            data_next[p*ppc_pkg::OUT_WIDTH +: ppc_pkg::OUT_WIDTH] =
                ppc_pkg::OUT_WIDTH'(cnt_next[p]);
        end
        data_next[ppc_pkg::NUM_POPS*ppc_pkg::OUT_WIDTH] = sizes_error;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            for (int p = 0; p < ppc_pkg::NUM_POPS; p++)
            begin
                cnt_reg[p] <= '0;
            end
        end
        else
        begin
            if (fire)
            begin
                for (int p = 0; p < ppc_pkg::NUM_POPS; p++)
                begin
                    cnt_reg[p] <= ctrl.last ? '0 : cnt_next[p];
                end
            end
            if (fire && ctrl.last)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && ctrl.last)
        begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

/* rtl/core/private_polymorphism_counter.sv */
// private_polymorphism_counter: top level. A column marked last passes the
// input, lane and output registers before its result is valid.
// Throughput: one column per cycle; the input stalls only while a finished
// result waits at the output and another last column is ready to merge.
// Reset (rst_n, async, active low) sets all sizes to 8, clears counters.
// Uses ppc_pkg, ppc_cfg, ppc_lane, ppc_merge.
module private_polymorphism_counter
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ppc_pkg::ADDR_WIDTH-1:0]    paddr,
    input  logic [ppc_pkg::APB_WIDTH-1:0]     pwdata,
    output logic [ppc_pkg::APB_WIDTH-1:0]     prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ppc_pkg::COL_WIDTH-1:0]     s_tdata,  // column_bits
    input  logic                              s_tlast,  // last_column
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // private_count_1 .. private_count_8, sizes_error, zero pad
    output logic [ppc_pkg::OUT_TDATA-1:0]     m_tdata
);

    ppc_pkg::col_t       seg_mask [ppc_pkg::NUM_POPS];
    logic                sizes_error;
    ppc_pkg::col_t       col_reg;
    logic                v1_reg;
    logic                last1_reg;
    logic                v2_reg;
    logic                last2_reg;
    ppc_pkg::beat_ctrl_t ctrl2;
    ppc_pkg::poly_t      poly;
    logic                stall;
    logic                en;

    assign en       = !stall;
    assign s_tready = en;
    assign ctrl2    = '{valid: v2_reg, last: last2_reg};

    ppc_cfg u_cfg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .seg_mask    (seg_mask),
        .sizes_error (sizes_error)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg   <= s_tdata;
            last1_reg <= s_tlast;
            last2_reg <= last1_reg;
        end
    end

    for (genvar p = 0; p < ppc_pkg::NUM_POPS; p++)
    begin : g_lane
        ppc_lane u_lane
        (
            .clk    (clk),
            .en     (en),
            .column (col_reg),
            .mask   (seg_mask[p]),
            .poly   (poly[p])
        );
    end

    ppc_merge u_merge
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl2),
        .poly        (poly),
        .sizes_error (sizes_error),
        .stall       (stall),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

/* bench/tb_private_polymorphism_counter.sv */
// tb_private_polymorphism_counter: self-checking bench for the private polymorphism
// counter, with random idling on both streams and APB size reconfiguration.
// Depends on ppc_pkg and private_polymorphism_counter.
module tb_private_polymorphism_counter;

    localparam int REG_STRIDE     = 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int PAD_BITS       = ppc_pkg::OUT_TDATA - ppc_pkg::OUT_BITS;

    typedef struct packed {
        logic [PAD_BITS-1:0]                                    pad;
        logic                                                   sizes_error;
        logic [ppc_pkg::NUM_POPS-1:0][ppc_pkg::OUT_WIDTH-1:0]   counts;
    } count_beat_t;

    typedef struct {
        ppc_pkg::col_t bits;
        logic          is_last;
        bit            drain;
    } column_item_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [ppc_pkg::ADDR_WIDTH-1:0]  paddr = '0;
    logic [ppc_pkg::APB_WIDTH-1:0]   pwdata = '0;
    logic [ppc_pkg::APB_WIDTH-1:0]   prdata;
    logic                            pready;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ppc_pkg::COL_WIDTH-1:0]   s_tdata = '0;   // column_bits
    logic                            s_tlast = 1'b0; // last_column
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // private_count_1 .. private_count_8, sizes_error, zero pad
    logic [ppc_pkg::OUT_TDATA-1:0]   m_tdata;

    ppc_pkg::size_t         size_reg [ppc_pkg::NUM_POPS];
    ppc_pkg::count_t        locus_count [ppc_pkg::NUM_POPS];
    column_item_t           col_fifo [$];
    count_beat_t            pending_counts [$];
    logic                   col_taken = 1'b0;
    bit                     no_idle = 1'b0;
    int                     gap_left = 0;
    int                     stall_left = 0;
    int                     idle_cycles = 0;
    int                     fail_count = 0;

    private_polymorphism_counter u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic ppc_pkg::col_t pop_mask(input int p);
        int            lo;
        int            hi;
        ppc_pkg::col_t m;
        lo = 0;
        for (int q = 0; q < p; q++)
        begin
            lo += size_reg[q];
        end
        hi = lo + size_reg[p];
        for (int i = 0; i < ppc_pkg::COL_WIDTH; i++)
        begin
            m[i] = (i >= lo) && (i < hi) && (i < ppc_pkg::MAX_HAPLOTYPES);
        end
        return m;
    endfunction

    task automatic count_private_site(input ppc_pkg::col_t bits, input logic is_last);
        int            npoly;
        int            hit;
        int            total;
        ppc_pkg::col_t seg;
        ppc_pkg::col_t ones;
        count_beat_t   res;
        npoly = 0;
        hit = 0;
        total = 0;
        for (int p = 0; p < ppc_pkg::NUM_POPS; p++)
        begin
            seg = pop_mask(p);
            ones = bits & seg;
            total += size_reg[p];
            if (ones != '0 && ones != seg)
            begin
                npoly++;
                hit = p;
            end
        end
        if (npoly == 1 && locus_count[hit] != '1)
            locus_count[hit]++;
        if (is_last)
        begin
            res = '0;
            for (int p = 0; p < ppc_pkg::NUM_POPS; p++)
            begin
                res.counts[p] = locus_count[p];
                locus_count[p] = '0;
            end
            res.sizes_error = total > ppc_pkg::MAX_HAPLOTYPES;
            pending_counts = {pending_counts, res};
        end
    endtask

    task automatic check_counts(input count_beat_t got);
        count_beat_t want;
        if (pending_counts.size() == 0)
        begin
            report_mismatch("unexpected result beat", got.counts[0], '0);
            return;
        end
        want = pending_counts.pop_front();
        for (int p = 0; p < ppc_pkg::NUM_POPS; p++)
        begin
            if (got.counts[p] !== want.counts[p])
                report_mismatch($sformatf("private_count_%0d", p + 1),
                                got.counts[p], want.counts[p]);
        end
        if (got.sizes_error !== want.sizes_error)
            report_mismatch("sizes_error", got.sizes_error, want.sizes_error);
        if (got.pad !== '0)
            report_mismatch("tdata pad", got.pad, '0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < ppc_pkg::NUM_POPS; p++)
            begin
                size_reg[p] <= ppc_pkg::SIZE_RESET;
                locus_count[p] = '0;
            end
            col_taken <= 1'b0;
        end
        else
        begin
            col_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                count_private_site(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_counts(count_beat_t'(m_tdata));
            if (psel && penable && pready)
            begin
                if (pwrite)
                    size_reg[paddr[4:2]] <= pwdata[ppc_pkg::SIZE_WIDTH-1:0];
                else if (prdata !== ppc_pkg::APB_WIDTH'(size_reg[paddr[4:2]]))
                    report_mismatch($sformatf("prdata reg %0d", paddr[4:2]),
                                    prdata, ppc_pkg::APB_WIDTH'(size_reg[paddr[4:2]]));
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("private_polymorphism_counter: mismatch");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    always @(negedge clk)
    begin
        column_item_t item;
        if (!rst_n || (s_tvalid && !col_taken))
            ;
        else if (gap_left > 0)
        begin
            s_tvalid <= 1'b0;
            gap_left--;
        end
        else if (col_fifo.size() > 0 &&
                 !(col_fifo[0].drain && pending_counts.size() > 0))
        begin
            item = col_fifo.pop_front();
            s_tdata <= item.bits;
            s_tlast <= item.is_last;
            s_tvalid <= 1'b1;
            gap_left = pick_gap();
        end
        else
            s_tvalid <= 1'b0;
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(99) < 20)
                stall_left = pick_gap();
        end
    end

    task automatic apb_access(input bit wr, input int idx, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ppc_pkg::ADDR_WIDTH'(idx * REG_STRIDE);
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (col_fifo.size() > 0 || s_tvalid || pending_counts.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sizes are written, then read back
    task automatic set_sizes(input int s0, s1, s2, s3, s4, s5, s6, s7, input bit junk);
        int sz [ppc_pkg::NUM_POPS];
        sz = '{s0, s1, s2, s3, s4, s5, s6, s7};
        wait_idle();
        for (int p = 0; p < ppc_pkg::NUM_POPS; p++)
        begin
            apb_access(1'b1, p, junk ? {$urandom} & 32'hFFFF_FF80 | 32'(sz[p] & 'h7F)
                                     : 32'(sz[p]));
        end
        for (int p = 0; p < ppc_pkg::NUM_POPS; p++)
        begin
            apb_access(1'b0, p, '0);
        end
    endtask

    task automatic push_column(input ppc_pkg::col_t bits, input logic is_last,
                               input bit drain = 1'b0);
        column_item_t item;
        item.bits = bits;
        item.is_last = is_last;
        item.drain = drain;
        col_fifo = {col_fifo, item};
    endtask

    // Mostly one mixed population among uniform ones, so private sites are common.
    function automatic ppc_pkg::col_t make_column();
        ppc_pkg::col_t bits;
        ppc_pkg::col_t seg;
        int            pick;
        int            target;
        int            second;
        bits = {$urandom, $urandom};
        pick = $urandom_range(99);
        target = $urandom_range(ppc_pkg::NUM_POPS - 1);
        second = $urandom_range(ppc_pkg::NUM_POPS - 1);
        if (pick < 80)
        begin
            for (int p = 0; p < ppc_pkg::NUM_POPS; p++)
            begin
                seg = pop_mask(p);
                if (p == target || (pick >= 65 && p == second))
                    continue;
                bits = $urandom_range(1) ? (bits | seg) : (bits & ~seg);
            end
        end
        else if (pick < 85)
            bits = $urandom_range(1) ? '1 : '0;
        return bits;
    endfunction

    task automatic random_phase(input int budget);
        int n;
        int len;
        int r;
        n = 0;
        while (n < budget)
        begin
            r = $urandom_range(99);
            len = (r < 40) ? 1 : (r < 80) ? $urandom_range(8, 2) : $urandom_range(40, 9);
            for (int k = 0; k < len; k++)
            begin
                push_column(make_column(), k == len - 1,
                            n == budget / 3 || $urandom_range(99) < 3);
                n++;
            end
        end
    endtask

    function automatic int rand_size(input int mode);
        if (mode == 0)
            return $urandom_range(8);
        if (mode == 1)
            return $urandom_range(16);
        if (mode == 2)
            return $urandom_range(64);
        return $urandom_range(127);
    endfunction

    initial
    begin
        int m;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_column('0, 1'b1);
        for (int p = 0; p < ppc_pkg::NUM_POPS; p++)
        begin
            push_column(ppc_pkg::col_t'(1) << (8 * p), 1'b0);
        end
        push_column('1, 1'b1);
        push_column(64'h0000_0000_0000_0101, 1'b0);
        push_column(64'h8000_0000_0000_0000, 1'b0);
        push_column('1, 1'b1);

        set_sizes(64, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        push_column(64'h8000_0000_0000_0000, 1'b1);
        set_sizes(0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        push_column(64'h5A5A_0F0F_3C3C_9669, 1'b1);
        set_sizes(127, 127, 127, 127, 127, 127, 127, 127, 1'b0);
        push_column(64'h0000_0000_0000_0002, 1'b1);
        set_sizes(60, 10, 0, 0, 0, 0, 0, 0, 1'b0);
        push_column(64'h1000_0000_0000_0000, 1'b0);
        push_column(64'h0FFF_FFFF_FFFF_FFFF, 1'b1);
        set_sizes(2, 3, 0, 1, 5, 0, 0, 4, 1'b0);
        push_column(64'hFFFF_FFFF_FFFF_0001, 1'b0);
        push_column(64'h0000_0000_0000_0020, 1'b1);
        set_sizes(9, 8, 8, 8, 8, 8, 8, 8, 1'b0);
        push_column(64'h0000_0000_0000_0100, 1'b1);

        set_sizes(8, 8, 8, 8, 8, 8, 8, 8, 1'b0);
        random_phase(180);
        for (int ph = 0; ph < 7; ph++)
        begin
            m = ph % 4;
            set_sizes(rand_size(m), rand_size(m), rand_size(m), rand_size(m),
                      rand_size(m), rand_size(m), rand_size(m), rand_size(m), 1'b1);
            no_idle = (ph == 3);
            random_phase(175);
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("private_polymorphism_counter: match");
        else
            $display("private_polymorphism_counter: mismatch");
        $finish;
    end

endmodule
